>>> rtl/irda_tx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irda_tx_pkg: shared types and constants
// Sizes, command codes, register indexes and the structs that drive and
// report the byte FIFO.
// ----------------------------------------------------------------------------
package irda_tx_pkg;

  // fifo geometry
  localparam int unsigned FIFO_DEPTH = 32;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  // frame geometry
  localparam int unsigned OVERSAMPLE    = 16;
  localparam int unsigned SUB_W         = $clog2(OVERSAMPLE);
  localparam int unsigned FRAME_SYMBOLS = 10;
  localparam int unsigned SYM_W         = $clog2(FRAME_SYMBOLS);
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned BIT_IDX_W     = $clog2(BYTE_W);
  localparam int unsigned PAT_W         = 16;

  // reset values of the pattern registers
  localparam logic [PAT_W-1:0] ZERO_PAT_RST = 16'h00E0;
  localparam logic [PAT_W-1:0] ONE_PAT_RST  = 16'h0000;

  // stream widths
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 16;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic [0:0] {
    REG_ZERO_PAT = 1'b0,
    REG_ONE_PAT  = 1'b1
  } reg_idx_e;

  // requests into the fifo
  typedef struct packed {
    logic              push;
    logic              pop;
    logic [BYTE_W-1:0] wdata;
  } fifo_ctrl_t;

  // fifo status
  typedef struct packed {
    logic             empty;
    logic             full;
    logic [CNT_W-1:0] count_next;
  } fifo_stat_t;

endpackage

>>> rtl/irda_tx_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irda_tx_fifo: byte queue
// Circular buffer with write and read pointers and a fill count. The read
// data is registered on a pop and then holds the byte in flight.
// ----------------------------------------------------------------------------
module irda_tx_fifo (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  irda_tx_pkg::fifo_ctrl_t             ctrl_i,
  output irda_tx_pkg::fifo_stat_t             stat_o,
  output logic [irda_tx_pkg::BYTE_W-1:0]      rd_data_o
);

  logic [irda_tx_pkg::BYTE_W-1:0] mem [irda_tx_pkg::FIFO_DEPTH];
  logic [irda_tx_pkg::PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [irda_tx_pkg::PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [irda_tx_pkg::CNT_W-1:0]  count_q, count_d;
  logic [irda_tx_pkg::BYTE_W-1:0] rd_data_q;

  localparam logic [irda_tx_pkg::PTR_W-1:0] PtrLast =
    irda_tx_pkg::PTR_W'(irda_tx_pkg::FIFO_DEPTH - 1);
  localparam logic [irda_tx_pkg::CNT_W-1:0] CntFull =
    irda_tx_pkg::CNT_W'(irda_tx_pkg::FIFO_DEPTH);

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (ctrl_i.push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      count_d  = count_q + 1'b1;
    end else if (ctrl_i.pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      count_d  = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage, write port and registered read port
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[wr_ptr_q] <= ctrl_i.wdata;
    end
    if (ctrl_i.pop) begin
      rd_data_q <= mem[rd_ptr_q];
    end
  end

  assign stat_o.empty      = (count_q == '0);
  assign stat_o.full       = (count_q == CntFull);
  assign stat_o.count_next = count_d;
  assign rd_data_o         = rd_data_q;

endmodule

>>> rtl/irda_tx_symbol.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irda_tx_symbol: frame sequencer
// Symbol and sub-bit counters for one frame, symbol pattern selection and
// the held line level.
// ----------------------------------------------------------------------------
module irda_tx_symbol (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               tick_i,
  input  logic                               fifo_empty_i,
  input  logic [irda_tx_pkg::BYTE_W-1:0]     cur_byte_i,
  input  logic [irda_tx_pkg::PAT_W-1:0]      zero_pat_i,
  input  logic [irda_tx_pkg::PAT_W-1:0]      one_pat_i,
  output logic                               pop_o,
  output logic                               level_next_o,
  output logic                               active_next_o
);

  localparam logic [irda_tx_pkg::SUB_W-1:0] SubLast =
    irda_tx_pkg::SUB_W'(irda_tx_pkg::OVERSAMPLE - 1);
  localparam logic [irda_tx_pkg::SYM_W-1:0] SymLast =
    irda_tx_pkg::SYM_W'(irda_tx_pkg::FRAME_SYMBOLS - 1);

  logic [irda_tx_pkg::SYM_W-1:0]     sym_q, sym_d;
  logic [irda_tx_pkg::SUB_W-1:0]     sub_q, sub_d;
  logic                              level_q, level_d;
  logic                              at_boundary;
  logic                              sending;
  logic                              is_one;
  logic [irda_tx_pkg::SYM_W-1:0]     sym_m1;
  logic [irda_tx_pkg::PAT_W-1:0]     pattern;

  assign at_boundary = (sym_q == '0) && (sub_q == '0);
  assign sending     = tick_i && !(at_boundary && fifo_empty_i);
  assign pop_o       = tick_i && at_boundary && !fifo_empty_i;

  // start symbol sends the zero pattern, stop symbol the one pattern
  assign sym_m1 = sym_q - 1'b1;
  always_comb begin
    if (sym_q == '0) begin
      is_one = 1'b0;
    end else if (sym_q >= SymLast) begin
      is_one = 1'b1;
    end else begin
      is_one = cur_byte_i[sym_m1[irda_tx_pkg::BIT_IDX_W-1:0]];
    end
  end
  assign pattern = is_one ? one_pat_i : zero_pat_i;

  // counter and level update
  always_comb begin
    sym_d   = sym_q;
    sub_d   = sub_q;
    level_d = level_q;
    if (sending) begin
      level_d = pattern[sub_q];
      if (sub_q == SubLast) begin
        sub_d = '0;
        sym_d = (sym_q == SymLast) ? '0 : sym_q + 1'b1;
      end else begin
        sub_d = sub_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_q   <= '0;
      sub_q   <= '0;
      level_q <= 1'b0;
    end else begin
      sym_q   <= sym_d;
      sub_q   <= sub_d;
      level_q <= level_d;
    end
  end

  assign level_next_o  = level_d;
  assign active_next_o = (sym_d != '0) || (sub_d != '0);

endmodule

>>> rtl/irda_uart_pulse_transmitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irda_uart_pulse_transmitter: IrDA-style UART pulse transmitter
// Queues pushed bytes and sends them as start/data/stop frames of pulse
// patterns, one sub-bit per tick request.
// ----------------------------------------------------------------------------
// Path: an accepted request passes the input register, then the result
//   register, before its result appears.
// Throughput: one request per cycle while the result side is not stalled;
//   the state update is one pass of the fifo pointers and frame counters.
// Reset: asynchronous, active low; empties the queue, ends any frame, line low,
//   patterns back to 0x00E0 and 0x0000.
// ----------------------------------------------------------------------------
module irda_uart_pulse_transmitter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // request stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [irda_tx_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [7:0] data_byte
  input  logic                                 s_axis_tuser,  // [0] command
  // result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [0] line_level, [1] push_dropped, [2] frame_active, [8:3] queued_count
  output logic [irda_tx_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // configuration writes
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [0:0]                           cfg_index_i,
  input  logic [irda_tx_pkg::PAT_W-1:0]        cfg_data_i
);

  logic [irda_tx_pkg::PAT_W-1:0]  zero_pat_q, one_pat_q;
  logic                           in_valid_q;
  logic                           in_cmd_q;
  logic [irda_tx_pkg::BYTE_W-1:0] in_data_q;
  logic                           out_valid_q;
  logic [irda_tx_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic                           advance;
  logic                           process;
  logic                           is_push;
  logic                           is_tick;
  logic                           dropped;
  logic                           pop;
  logic                           level_next;
  logic                           active_next;
  logic [irda_tx_pkg::BYTE_W-1:0] cur_byte;
  irda_tx_pkg::fifo_ctrl_t        fifo_ctrl;
  irda_tx_pkg::fifo_stat_t        fifo_stat;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_pat_q <= irda_tx_pkg::ZERO_PAT_RST;
      one_pat_q  <= irda_tx_pkg::ONE_PAT_RST;
    end else if (cfg_valid_i) begin
      case (irda_tx_pkg::reg_idx_e'(cfg_index_i))
        irda_tx_pkg::REG_ZERO_PAT: zero_pat_q <= cfg_data_i;
        irda_tx_pkg::REG_ONE_PAT:  one_pat_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign process       = in_valid_q && advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd_q  <= s_axis_tuser;
      in_data_q <= s_axis_tdata[irda_tx_pkg::BYTE_W-1:0];
    end
  end

  // request decode
  assign is_push = process && (irda_tx_pkg::cmd_e'(in_cmd_q) == irda_tx_pkg::CMD_PUSH);
  assign is_tick = process && (irda_tx_pkg::cmd_e'(in_cmd_q) == irda_tx_pkg::CMD_TICK);
  assign dropped = is_push && fifo_stat.full;

  assign fifo_ctrl.push  = is_push && !fifo_stat.full;
  assign fifo_ctrl.pop   = pop;
  assign fifo_ctrl.wdata = in_data_q;

  irda_tx_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (fifo_ctrl),
    .stat_o    (fifo_stat),
    .rd_data_o (cur_byte)
  );

  irda_tx_symbol u_symbol (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_i        (is_tick),
    .fifo_empty_i  (fifo_stat.empty),
    .cur_byte_i    (cur_byte),
    .zero_pat_i    (zero_pat_q),
    .one_pat_i     (one_pat_q),
    .pop_o         (pop),
    .level_next_o  (level_next),
    .active_next_o (active_next)
  );

  // result packing
  always_comb begin
    out_data_d = '0;
    out_data_d[0] = level_next;
    out_data_d[1] = dropped;
    out_data_d[2] = active_next;
    out_data_d[3 +: irda_tx_pkg::CNT_W] = fifo_stat.count_next;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[3 +: irda_tx_pkg::CNT_W] <= irda_tx_pkg::CNT_W'(irda_tx_pkg::FIFO_DEPTH)))
    else $error("queued count above fifo depth");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[1]) |->
      (m_axis_tdata[3 +: irda_tx_pkg::CNT_W] == irda_tx_pkg::CNT_W'(irda_tx_pkg::FIFO_DEPTH)))
    else $error("push dropped while fifo not full");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (!fifo_stat.empty && !fifo_ctrl.push))
    else $error("pop from empty fifo or with a push");

  a_full_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fifo_stat.full && fifo_stat.empty))
    else $error("fifo full and empty at once");

endmodule

>>> tb/sv/irda_tx_line_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irda_tx_line_checker: result predictor and comparator for the transmitter
// Watches the request, result and configuration channels. Models the byte
// queue and the frame sequencer for each accepted request, then compares
// every accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module irda_tx_line_checker
  import irda_tx_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request channel
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [IN_DATA_W-1:0]  s_tdata_i,   // [7:0] data_byte
  input  logic                  s_tuser_i,   // [0] command
  // result channel
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  // [0] line_level, [1] push_dropped, [2] frame_active, [8:3] queued_count
  input  logic [OUT_DATA_W-1:0] m_tdata_i,
  // configuration channel
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [0:0]            cfg_index_i,
  input  logic [PAT_W-1:0]      cfg_data_i,
  // status towards the test top
  output int                    errors_o,
  output int                    pending_o,
  output int                    results_o,
  output int                    frames_o,
  output int                    drops_o
);

  localparam int PRINT_CAP  = 40;
  localparam int FRAME_TICKS = FRAME_SYMBOLS * OVERSAMPLE;

  // one result, laid out as the low bits of the result tdata
  typedef struct packed {
    logic [CNT_W-1:0] queued_count;
    logic             frame_active;
    logic             push_dropped;
    logic             line_level;
  } line_result_t;

  localparam int RESULT_W = $bits(line_result_t);

  // model of the transmitter state
  logic [BYTE_W-1:0] byte_store [FIFO_DEPTH];
  int                rd_ptr;
  int                wr_ptr;
  int                queued;
  int                tick_pos;
  logic [BYTE_W-1:0] cur_byte;
  logic              held_level;
  logic [PAT_W-1:0]  zero_pat;
  logic [PAT_W-1:0]  one_pat;

  line_result_t line_results_q [$];

  // one line per mismatch, printing capped to keep the log short
  task automatic report_mismatch(string msg);
    if (errors_o < PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    errors_o++;
  endtask

  // advance the model by one request and return the line status after it
  function automatic line_result_t predict_line_result(cmd_e cmd, logic [BYTE_W-1:0] byte_val);
    line_result_t     res;
    int               symbol;
    int               sub;
    logic             is_one;
    logic             sending;
    logic [PAT_W-1:0] pattern;
    res = '0;
    if (cmd == CMD_PUSH) begin
      // a full queue drops the byte and leaves everything else alone
      if (queued >= FIFO_DEPTH) begin
        res.push_dropped = 1'b1;
        drops_o++;
      end else begin
        byte_store[wr_ptr] = byte_val;
        wr_ptr = (wr_ptr + 1) % FIFO_DEPTH;
        queued++;
      end
    end else begin
      sending = (tick_pos != 0);
      // frame boundary: take the next byte, or hold the line when empty
      if (!sending && queued != 0) begin
        cur_byte = byte_store[rd_ptr];
        rd_ptr = (rd_ptr + 1) % FIFO_DEPTH;
        queued--;
        sending = 1'b1;
      end
      if (sending) begin
        symbol = tick_pos / OVERSAMPLE;
        sub    = tick_pos % OVERSAMPLE;
        if (symbol == 0) begin
          is_one = 1'b0;
        end else if (symbol >= FRAME_SYMBOLS - 1) begin
          is_one = 1'b1;
        end else begin
          is_one = cur_byte[symbol-1];
        end
        pattern    = is_one ? one_pat : zero_pat;
        held_level = pattern[sub];
        tick_pos++;
        if (tick_pos >= FRAME_TICKS) begin
          tick_pos = 0;
          frames_o++;
        end
      end
    end
    res.line_level   = held_level;
    res.frame_active = (tick_pos != 0);
    res.queued_count = CNT_W'(queued);
    return res;
  endfunction

  // sample all channels at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    line_result_t want;
    line_result_t got;
    if (!rst_ni) begin
      rd_ptr     = 0;
      wr_ptr     = 0;
      queued     = 0;
      tick_pos   = 0;
      cur_byte   = '0;
      held_level = 1'b0;
      zero_pat   = ZERO_PAT_RST;
      one_pat    = ONE_PAT_RST;
      errors_o   = 0;
      results_o  = 0;
      frames_o   = 0;
      drops_o    = 0;
      line_results_q.delete();
    end else begin
      // compare a delivered result with the oldest prediction
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i[RESULT_W-1:0];
        if (line_results_q.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing predicted, tdata 0x%04h",
                                    results_o, m_tdata_i));
        end else begin
          want = line_results_q.pop_front();
          if (got.line_level !== want.line_level)
            report_mismatch($sformatf("result %0d line_level got %0b want %0b",
                                      results_o, got.line_level, want.line_level));
          if (got.push_dropped !== want.push_dropped)
            report_mismatch($sformatf("result %0d push_dropped got %0b want %0b",
                                      results_o, got.push_dropped, want.push_dropped));
          if (got.frame_active !== want.frame_active)
            report_mismatch($sformatf("result %0d frame_active got %0b want %0b",
                                      results_o, got.frame_active, want.frame_active));
          if (got.queued_count !== want.queued_count)
            report_mismatch($sformatf("result %0d queued_count got %0d want %0d",
                                      results_o, got.queued_count, want.queued_count));
          if (m_tdata_i[OUT_DATA_W-1:RESULT_W] !== '0)
            report_mismatch($sformatf("result %0d padding bits not zero, tdata 0x%04h",
                                      results_o, m_tdata_i));
        end
        results_o++;
      end
      // pattern register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_ZERO_PAT: zero_pat = cfg_data_i;
          REG_ONE_PAT:  one_pat  = cfg_data_i;
          default: ;
        endcase
      end
      // predict the result of an accepted request
      if (s_tvalid_i && s_tready_i) begin
        line_results_q.push_back(predict_line_result(cmd_e'(s_tuser_i), s_tdata_i));
      end
    end
    pending_o <= line_results_q.size();
  end

endmodule

>>> tb/sv/tb_irda_uart_pulse_transmitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_irda_uart_pulse_transmitter: stimulus and verdict for the transmitter
// Drives push and tick requests through several pattern settings, with
// random gaps on the request side and random stalls on the result side,
// and leaves prediction and comparison to the line checker.
// ----------------------------------------------------------------------------
module tb_irda_uart_pulse_transmitter;
  import irda_tx_pkg::*;

  localparam int DUT_LATENCY  = 2;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_COUNT  = 6;
  localparam int PHASE_ITEMS  = 200;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // [7:0] data_byte
  logic                  s_axis_tuser  = 1'b0; // [0] command
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [0] line_level, [1] push_dropped, [2] frame_active, [8:3] queued_count
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [0:0]            cfg_index_i   = '0;
  logic [PAT_W-1:0]      cfg_data_i    = '0;

  int  err_count;
  int  pending;
  int  results_seen;
  int  frames_sent;
  int  pushes_dropped;
  int  items_sent  = 0;
  int  cycle_count = 0;
  bit  idle_en     = 1'b1;

  irda_uart_pulse_transmitter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  irda_tx_line_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .errors_o    (err_count),
    .pending_o   (pending),
    .results_o   (results_seen),
    .frames_o    (frames_sent),
    .drops_o     (pushes_dropped)
  );

  // 100 MHz clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // result side: ready with random stall bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (idle_en && $urandom_range(0, 6) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // one request, with an occasional gap in front of it
  task automatic send_request(cmd_e cmd, logic [BYTE_W-1:0] byte_val);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= byte_val;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // hold off requests until every predicted result has been delivered
  task automatic wait_until_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DUT_LATENCY + 2) @(posedge clk_i);
  endtask

  // write both pattern registers back to back
  task automatic write_patterns(logic [PAT_W-1:0] zero_val, logic [PAT_W-1:0] one_val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_ZERO_PAT;
    cfg_data_i  <= zero_val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= REG_ONE_PAT;
    cfg_data_i  <= one_val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly long tick runs with short push bursts, so the queue fills and empties
  task automatic run_random_traffic(int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 4) == 0) begin
        len = $urandom_range(1, 3);
        if (len > n_items - sent) len = n_items - sent;
        repeat (len) send_request(CMD_PUSH, BYTE_W'($urandom_range(0, 255)));
      end else begin
        len = $urandom_range(1, 200);
        if (len > n_items - sent) len = n_items - sent;
        repeat (len) send_request(CMD_TICK, BYTE_W'($urandom()));
      end
      sent += len;
      // now and then let the pipeline empty in the middle of a frame
      if ($urandom_range(0, 9) == 0) wait_until_drained();
    end
  endtask

  // main sequence
  initial begin
    logic [PAT_W-1:0] zero_val;
    logic [PAT_W-1:0] one_val;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle ticks on an empty queue, extreme bytes, start of a frame
    send_request(CMD_TICK, 8'h00);
    send_request(CMD_TICK, 8'hFF);
    send_request(CMD_PUSH, 8'h00);
    send_request(CMD_PUSH, 8'hFF);
    send_request(CMD_PUSH, 8'hA5);
    repeat (18) send_request(CMD_TICK, BYTE_W'($urandom()));
    wait_until_drained();

    // random phases over several pattern settings
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        1:       begin zero_val = 16'hFFFF; one_val = 16'h0000; end
        2:       begin zero_val = 16'h0000; one_val = 16'hFFFF; end
        3:       begin zero_val = PAT_W'($urandom()); one_val = PAT_W'($urandom()); end
        4:       begin zero_val = 16'h5555; one_val = 16'hAAAA; end
        default: begin zero_val = ZERO_PAT_RST; one_val = ONE_PAT_RST; end
      endcase
      if (phase > 0) write_patterns(zero_val, one_val);
      if (phase == PHASE_COUNT - 1) begin
        // last phase: no idling, and overfill the queue
        idle_en = 1'b0;
        repeat (FIFO_DEPTH + 4) send_request(CMD_PUSH, BYTE_W'($urandom_range(0, 255)));
      end
      run_random_traffic(PHASE_ITEMS);
      wait_until_drained();
    end

    $display("covered %0d requests over %0d pattern settings, %0d results checked",
             items_sent, PHASE_COUNT, results_seen);
    $display("%0d frames sent in full, %0d pushes dropped on a full queue",
             frames_sent, pushes_dropped);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/irda_tx_pkg.sv
rtl/irda_tx_fifo.sv
rtl/irda_tx_symbol.sv
rtl/irda_uart_pulse_transmitter.sv
tb/sv/irda_tx_line_checker.sv
tb/sv/tb_irda_uart_pulse_transmitter.sv
